// ----- src/i2cmw_pkg.sv -----
package i2cmw_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic CMD_SEND = 1'b0;
  localparam logic CMD_ACK  = 1'b1;

  localparam logic [1:0] PIN_SDA  = 2'd0;
  localparam logic [1:0] PIN_SCL  = 2'd1;
  localparam logic [1:0] PIN_NONE = 2'd2;

  localparam logic [2:0] STAT_PROGRESS = 3'd0;
  localparam logic [2:0] STAT_ACKED    = 3'd1;
  localparam logic [2:0] STAT_NACK     = 3'd2;
  localparam logic [2:0] STAT_DONE     = 3'd3;
  localparam logic [2:0] STAT_IGNORED  = 3'd4;

  localparam logic [2:0] BIT_LAST = 3'd7;

  typedef enum logic [2:0] {
    JOB_SEND,
    JOB_ACK,
    JOB_NACK,
    JOB_STOP,
    JOB_IGNORE
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic       with_start;
    logic [7:0] data_byte;
  } job_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_START_SDA,
    BK_START_SCL,
    BK_BIT_SDA,
    BK_BIT_SCLH,
    BK_BIT_SCLL,
    BK_REL_SDA,
    BK_REL_SCL,
    BK_ACK_SCL,
    BK_NACK_SDA,
    BK_NACK_SCL,
    BK_STOP_SCL,
    BK_STOP_SDA,
    BK_IGNORE
  } bk_state_t;

endpackage

// ----- src/i2c_master_write_sequencer.sv -----
// Channel | Ports                                                   | Handshake
// input   | in_cmd in_data_byte in_is_address in_is_final            | in_push / in_full
//         | in_sda_sample                                           |
// result  | out_pin out_level out_status out_last                   | out_pop / out_empty
//
// The back sequencer sends one pin action per cycle while no result waits unpopped,
// and it is the limit: an item takes 1 to 28 actions, 28 for a byte with START,
// 26 without, 3 for NACK or STOP, 1 for a plain ACK or an ignored item.
// Reset is synchronous and active low; the bus state and the queue clear.
// The front takes items into a small job queue while the back works; the
// output register stalls the sequencer only while a result waits unpopped.
module i2c_master_write_sequencer
  import i2cmw_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic       in_cmd,
  input  logic [7:0] in_data_byte,
  input  logic       in_is_address,
  input  logic       in_is_final,
  input  logic       in_sda_sample,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [1:0] out_pin,
  output logic       out_level,
  output logic [2:0] out_status,
  output logic       out_last
);

  logic q_full;
  logic q_push;
  job_t q_push_job;
  logic q_pop;
  logic q_valid;
  job_t q_pop_job;

  i2cmw_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_cmd        (in_cmd),
    .in_data_byte  (in_data_byte),
    .in_is_address (in_is_address),
    .in_is_final   (in_is_final),
    .in_sda_sample (in_sda_sample),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (q_push_job)
  );

  i2cmw_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_push_job),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_job  (q_pop_job)
  );

  i2cmw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_job      (q_pop_job),
    .q_pop      (q_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_pin    (out_pin),
    .out_level  (out_level),
    .out_status (out_status),
    .out_last   (out_last)
  );

endmodule

// ----- src/i2cmw_front.sv -----
module i2cmw_front
  import i2cmw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic       in_cmd,
  input  logic [7:0] in_data_byte,
  input  logic       in_is_address,
  input  logic       in_is_final,
  input  logic       in_sda_sample,
  input  logic       q_full,
  output logic       q_push,
  output job_t       q_job
);

  logic awaiting_ack_r, awaiting_ack_nxt;
  logic stop_pending_r, stop_pending_nxt;

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

  always_comb begin
    awaiting_ack_nxt     = awaiting_ack_r;
    stop_pending_nxt     = stop_pending_r;
    q_job.kind           = JOB_IGNORE;
    q_job.with_start     = in_is_address;
    q_job.data_byte      = in_data_byte;
    if (in_cmd == CMD_SEND) begin
      if (!awaiting_ack_r) begin
        q_job.kind       = JOB_SEND;
        awaiting_ack_nxt = 1'b1;
        stop_pending_nxt = in_is_final;
      end
    end else if (awaiting_ack_r) begin
      awaiting_ack_nxt = 1'b0;
      stop_pending_nxt = 1'b0;
      if (in_sda_sample) begin
        q_job.kind = JOB_NACK;
      end else if (stop_pending_r) begin
        q_job.kind = JOB_STOP;
      end else begin
        q_job.kind = JOB_ACK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_ack_r <= 1'b0;
      stop_pending_r <= 1'b0;
    end else if (q_push) begin
      awaiting_ack_r <= awaiting_ack_nxt;
      stop_pending_r <= stop_pending_nxt;
    end
  end

`ifndef SYNTHESIS
  a_stop_needs_ack: assert property (@(posedge clk) disable iff (!rst_n)
    !awaiting_ack_r |-> !stop_pending_r)
    else $error("stop pending without an outstanding ack");
`endif

endmodule

// ----- src/i2cmw_queue.sv -----
module i2cmw_queue
  import i2cmw_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t pop_job
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign valid   = (count_r != '0);
  assign pop_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

// ----- src/i2cmw_back.sv -----
module i2cmw_back
  import i2cmw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  job_t       q_job,
  output logic       q_pop,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [1:0] out_pin,
  output logic       out_level,
  output logic [2:0] out_status,
  output logic       out_last
);

  bk_state_t  state_r, state_nxt;
  job_kind_t  kind_r, kind_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic [2:0] bit_cnt_r, bit_cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_pin_r, out_pin_nxt;
  logic       out_level_r, out_level_nxt;
  logic [2:0] out_status_r, out_status_nxt;
  logic       out_last_r, out_last_nxt;

  logic [1:0] act_pin;
  logic       act_level;
  logic [2:0] act_status;
  logic       act_last;
  bk_state_t  act_next;
  bk_state_t  first_state;
  logic       adv;
  logic       emit;
  logic       load;

  assign out_empty  = !out_valid_r;
  assign out_pin    = out_pin_r;
  assign out_level  = out_level_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;
  assign q_pop      = load;

  // Pin action for the current state
  always_comb begin
    act_pin    = PIN_NONE;
    act_level  = 1'b0;
    act_status = STAT_PROGRESS;
    act_last   = 1'b0;
    act_next   = BK_IDLE;
    unique case (state_r)
      BK_IDLE: begin
      end
      BK_START_SDA: begin
        act_pin  = PIN_SDA;
        act_next = BK_START_SCL;
      end
      BK_START_SCL: begin
        act_pin  = PIN_SCL;
        act_next = BK_BIT_SDA;
      end
      BK_BIT_SDA: begin
        act_pin   = PIN_SDA;
        act_level = byte_r[7];
        act_next  = BK_BIT_SCLH;
      end
      BK_BIT_SCLH: begin
        act_pin   = PIN_SCL;
        act_level = 1'b1;
        act_next  = BK_BIT_SCLL;
      end
      BK_BIT_SCLL: begin
        act_pin  = PIN_SCL;
        act_next = (bit_cnt_r == BIT_LAST) ? BK_REL_SDA : BK_BIT_SDA;
      end
      BK_REL_SDA: begin
        act_pin   = PIN_SDA;
        act_level = 1'b1;
        act_next  = BK_REL_SCL;
      end
      BK_REL_SCL: begin
        act_pin   = PIN_SCL;
        act_level = 1'b1;
        act_last  = 1'b1;
      end
      BK_ACK_SCL: begin
        act_pin = PIN_SCL;
        if (kind_r == JOB_NACK) begin
          act_next = BK_NACK_SDA;
        end else if (kind_r == JOB_STOP) begin
          act_next = BK_STOP_SCL;
        end else begin
          act_status = STAT_ACKED;
          act_last   = 1'b1;
        end
      end
      BK_NACK_SDA: begin
        act_pin   = PIN_SDA;
        act_level = 1'b1;
        act_next  = BK_NACK_SCL;
      end
      BK_NACK_SCL: begin
        act_pin    = PIN_SCL;
        act_level  = 1'b1;
        act_status = STAT_NACK;
        act_last   = 1'b1;
      end
      BK_STOP_SCL: begin
        act_pin   = PIN_SCL;
        act_level = 1'b1;
        act_next  = BK_STOP_SDA;
      end
      BK_STOP_SDA: begin
        act_pin    = PIN_SDA;
        act_level  = 1'b1;
        act_status = STAT_DONE;
        act_last   = 1'b1;
      end
      BK_IGNORE: begin
        act_status = STAT_IGNORED;
        act_last   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    unique case (q_job.kind) inside
      JOB_SEND:   first_state = q_job.with_start ? BK_START_SDA : BK_BIT_SDA;
      JOB_ACK,
      JOB_NACK,
      JOB_STOP:   first_state = BK_ACK_SCL;
      JOB_IGNORE: first_state = BK_IGNORE;
      default:    first_state = BK_IGNORE;
    endcase
  end

  always_comb begin
    adv  = !out_valid_r || out_pop;
    emit = adv && (state_r != BK_IDLE);
    // Chain straight into the next job after the last action of this one
    load = q_valid && ((state_r == BK_IDLE) || (emit && act_last));

    state_nxt      = state_r;
    kind_nxt       = kind_r;
    byte_nxt       = byte_r;
    bit_cnt_nxt    = bit_cnt_r;
    out_valid_nxt  = out_valid_r;
    out_pin_nxt    = out_pin_r;
    out_level_nxt  = out_level_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;

    if (adv) begin
      out_valid_nxt = emit;
    end
    if (emit) begin
      state_nxt      = act_next;
      out_pin_nxt    = act_pin;
      out_level_nxt  = act_level;
      out_status_nxt = act_status;
      out_last_nxt   = act_last;
      if (state_r == BK_BIT_SCLL) begin
        byte_nxt    = {byte_r[6:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + 1'b1;
      end
    end
    if (load) begin
      state_nxt   = first_state;
      kind_nxt    = q_job.kind;
      byte_nxt    = q_job.data_byte;
      bit_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      bit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    byte_r       <= byte_nxt;
    out_pin_r    <= out_pin_nxt;
    out_level_r  <= out_level_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

`ifndef SYNTHESIS
  a_cnt_outside_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != BK_BIT_SDA && state_r != BK_BIT_SCLH && state_r != BK_BIT_SCLL)
    |-> (bit_cnt_r == '0))
    else $error("bit counter not cleared outside the byte");
  a_status_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != STAT_PROGRESS) |-> out_last_r)
    else $error("final status on a result that is not last");
  a_ignored_no_pin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STAT_IGNORED) |-> (out_pin_r == PIN_NONE))
    else $error("ignored item moved a pin");
  a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> q_valid)
    else $error("job taken from an empty queue");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import i2cmw_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 470;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned ROW_COUNT    = 20;

  typedef struct packed {
    logic [1:0] pin;
    logic       level;
    logic [2:0] status;
    logic       last;
  } bus_action_t;

  // typed_check rows carry their single expected action in pin/level/status
  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
    logic       is_address;
    logic       is_final;
    logic       sda_sample;
    logic       typed_check;
    logic [1:0] pin;
    logic       level;
    logic [2:0] status;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [ROW_COUNT] = '{
    '{CMD_ACK,  8'h00, 1'b0, 1'b0, 1'b0, 1'b1, PIN_NONE, 1'b0, STAT_IGNORED},
    '{CMD_SEND, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, PIN_NONE, 1'b0, STAT_PROGRESS},
    '{CMD_SEND, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1, PIN_NONE, 1'b0, STAT_IGNORED},
    '{CMD_ACK,  8'h00, 1'b0, 1'b0, 1'b0, 1'b1, PIN_SCL,  1'b0, STAT_ACKED},
    '{CMD_ACK,  8'h00, 1'b0, 1'b0, 1'b0, 1'b1, PIN_NONE, 1'b0, STAT_IGNORED},
    '{CMD_SEND, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, PIN_NONE, 1'b0, STAT_PROGRESS},
    '{CMD_ACK,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, PIN_NONE, 1'b0, STAT_PROGRESS},
    '{CMD_SEND, 8'hA5, 1'b1, 1'b0, 1'b0, 1'b0, PIN_NONE, 1'b0, STAT_PROGRESS},
    '{CMD_ACK,  8'h00, 1'b0, 1'b0, 1'b1, 1'b0, PIN_NONE, 1'b0, STAT_PROGRESS},
    '{CMD_ACK,  8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, PIN_NONE, 1'b0, STAT_IGNORED},
    '{CMD_SEND, 8'h5A, 1'b0, 1'b0, 1'b1, 1'b0, PIN_NONE, 1'b0, STAT_PROGRESS},
    '{CMD_ACK,  8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, PIN_SCL,  1'b0, STAT_ACKED},
    '{CMD_SEND, 8'h80, 1'b1, 1'b0, 1'b0, 1'b0, PIN_NONE, 1'b0, STAT_PROGRESS},
    '{CMD_ACK,  8'h00, 1'b0, 1'b0, 1'b0, 1'b1, PIN_SCL,  1'b0, STAT_ACKED},
    '{CMD_SEND, 8'h01, 1'b0, 1'b1, 1'b1, 1'b0, PIN_NONE, 1'b0, STAT_PROGRESS},
    '{CMD_ACK,  8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, PIN_NONE, 1'b0, STAT_PROGRESS},
    '{CMD_SEND, 8'h7F, 1'b1, 1'b1, 1'b0, 1'b0, PIN_NONE, 1'b0, STAT_PROGRESS},
    '{CMD_ACK,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, PIN_NONE, 1'b0, STAT_PROGRESS},
    '{CMD_SEND, 8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, PIN_NONE, 1'b0, STAT_PROGRESS},
    '{CMD_ACK,  8'h00, 1'b1, 1'b0, 1'b0, 1'b0, PIN_NONE, 1'b0, STAT_PROGRESS}
  };

  logic       clk;
  logic       rst_n;
  logic       in_push;
  logic       in_full;
  logic       in_cmd;
  logic [7:0] in_data_byte;
  logic       in_is_address;
  logic       in_is_final;
  logic       in_sda_sample;
  logic       out_empty;
  logic       out_pop;
  logic [1:0] out_pin;
  logic       out_level;
  logic [2:0] out_status;
  logic       out_last;

  bus_action_t expected_actions [$];
  logic        ack_due;
  logic        stop_after_ack;
  logic        send_burst;
  logic        pop_burst;
  int unsigned pop_wait;
  int unsigned stall_cycles;
  int unsigned error_count;
  int unsigned items_accepted;
  int unsigned useful_items;
  int unsigned actions_checked;
  int unsigned transfers_done;
  int unsigned transfers_aborted;
  int unsigned items_ignored;

  i2c_master_write_sequencer u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_cmd       (in_cmd),
    .in_data_byte (in_data_byte),
    .in_is_address(in_is_address),
    .in_is_final  (in_is_final),
    .in_sda_sample(in_sda_sample),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_pin      (out_pin),
    .out_level    (out_level),
    .out_status   (out_status),
    .out_last     (out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bus_action_t act(input logic [1:0] pin, input logic level);
    bus_action_t a;
    a.pin    = pin;
    a.level  = level;
    a.status = STAT_PROGRESS;
    a.last   = 1'b0;
    return a;
  endfunction

  // Advance the bus state by one accepted item and queue the pin actions it causes.
  function automatic void sequence_pin_actions(input stim_row_t row);
    bus_action_t acts [28];
    bus_action_t a;
    int          n;
    logic [7:0]  shift;
    logic [2:0]  closing;
    n = 0;
    shift = row.data_byte;
    closing = STAT_PROGRESS;
    if ((row.cmd == CMD_SEND && ack_due) || (row.cmd == CMD_ACK && !ack_due)) begin
      acts[n] = act(PIN_NONE, 1'b0);
      n++;
      closing = STAT_IGNORED;
    end else if (row.cmd == CMD_SEND) begin
      if (row.is_address) begin
        acts[n] = act(PIN_SDA, 1'b0);
        n++;
        acts[n] = act(PIN_SCL, 1'b0);
        n++;
      end
      for (int b = 0; b < 8; b++) begin
        acts[n] = act(PIN_SDA, shift[7]);
        n++;
        acts[n] = act(PIN_SCL, 1'b1);
        n++;
        acts[n] = act(PIN_SCL, 1'b0);
        n++;
        shift = shift << 1;
      end
      // release SDA and raise SCL for the acknowledge clock
      acts[n] = act(PIN_SDA, 1'b1);
      n++;
      acts[n] = act(PIN_SCL, 1'b1);
      n++;
      ack_due = 1'b1;
      stop_after_ack = row.is_final;
    end else begin
      acts[n] = act(PIN_SCL, 1'b0);
      n++;
      ack_due = 1'b0;
      if (row.sda_sample) begin
        acts[n] = act(PIN_SDA, 1'b1);
        n++;
        acts[n] = act(PIN_SCL, 1'b1);
        n++;
        closing = STAT_NACK;
        stop_after_ack = 1'b0;
      end else if (stop_after_ack) begin
        acts[n] = act(PIN_SCL, 1'b1);
        n++;
        acts[n] = act(PIN_SDA, 1'b1);
        n++;
        closing = STAT_DONE;
        stop_after_ack = 1'b0;
      end else begin
        closing = STAT_ACKED;
      end
    end
    if (closing != STAT_IGNORED) useful_items++;
    if (row.typed_check) begin
      a.pin    = row.pin;
      a.level  = row.level;
      a.status = row.status;
      a.last   = 1'b1;
      expected_actions.push_back(a);
    end else begin
      for (int k = 0; k < n; k++) begin
        a = acts[k];
        if (k == n - 1) begin
          a.status = closing;
          a.last   = 1'b1;
        end
        expected_actions.push_back(a);
      end
    end
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t r;
    r = '0;
    r.cmd        = 1'($urandom_range(0, 1));
    r.data_byte  = 8'($urandom_range(0, 255));
    r.is_address = 1'($urandom_range(0, 1));
    r.is_final   = 1'($urandom_range(0, 1));
    r.sda_sample = 1'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic drive_item(input stim_row_t row);
    int unsigned gap;
    if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push       <= 1'b1;
    in_cmd        <= row.cmd;
    in_data_byte  <= row.data_byte;
    in_is_address <= row.is_address;
    in_is_final   <= row.is_final;
    in_sda_sample <= row.sda_sample;
    @(posedge clk);
    while (in_full) @(posedge clk);
    items_accepted++;
    sequence_pin_actions(row);
  endtask

  // Mostly well-formed write transfers, with some noise and early aborts mixed in.
  task automatic drive_transfer();
    stim_row_t   r;
    int unsigned nbytes;
    nbytes = $urandom_range(1, 4);
    for (int b = 0; b < nbytes; b++) begin
      if ($urandom_range(0, 7) == 0) drive_item(random_row());
      r = random_row();
      r.cmd = CMD_SEND;
      r.is_address = (b == 0) ? ($urandom_range(0, 15) != 0) : ($urandom_range(0, 15) == 0);
      r.is_final = (b == nbytes - 1) ? ($urandom_range(0, 3) != 0) : 1'b0;
      drive_item(r);
      if ($urandom_range(0, 19) == 0) break;
      r = random_row();
      r.cmd = CMD_ACK;
      r.sda_sample = ($urandom_range(0, 9) == 0);
      drive_item(r);
      if (r.sda_sample) break;
    end
  endtask

  always @(posedge clk) begin : result_check
    bus_action_t got;
    bus_action_t want;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        got.pin    = out_pin;
        got.level  = out_level;
        got.status = out_status;
        got.last   = out_last;
        actions_checked++;
        if (got.last && got.status == STAT_DONE) transfers_done++;
        if (got.last && got.status == STAT_NACK) transfers_aborted++;
        if (got.last && got.status == STAT_IGNORED) items_ignored++;
        if (expected_actions.size() == 0) begin
          $error("unexpected pin action: pin %0d level %0d status %0d last %0d",
                 got.pin, got.level, got.status, got.last);
          error_count++;
        end else begin
          want = expected_actions.pop_front();
          if (got.pin != want.pin) begin
            $error("pin: expected %0d, got %0d", want.pin, got.pin);
            error_count++;
          end
          if (got.level != want.level) begin
            $error("level: expected %0d, got %0d", want.level, got.level);
            error_count++;
          end
          if (got.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            error_count++;
          end
          if (got.last != want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            error_count++;
          end
        end
        if ($urandom_range(0, 63) == 0) pop_burst = !pop_burst;
        pop_wait = pop_burst ? 0 : $urandom_range(0, 7);
      end else if (pop_wait != 0) begin
        pop_wait--;
      end
      out_pop <= (pop_wait == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_push         = 1'b0;
    in_cmd          = CMD_SEND;
    in_data_byte    = 8'h00;
    in_is_address   = 1'b0;
    in_is_final     = 1'b0;
    in_sda_sample   = 1'b0;
    out_pop         = 1'b0;
    ack_due         = 1'b0;
    stop_after_ack  = 1'b0;
    send_burst      = 1'b0;
    pop_burst       = 1'b0;
    pop_wait        = 0;
    stall_cycles    = 0;
    error_count     = 0;
    items_accepted  = 0;
    useful_items    = 0;
    actions_checked = 0;
    transfers_done  = 0;
    transfers_aborted = 0;
    items_ignored   = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < ROW_COUNT; i++) drive_item(DIRECTED_ROWS[i]);
    while (useful_items < ROW_COUNT + RANDOM_ITEMS) drive_transfer();
    in_push <= 1'b0;
    while (expected_actions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d items and %0d pin actions", items_accepted, actions_checked);
    $display("%0d transfers stopped, %0d aborted on NACK, %0d out-of-order items",
             transfers_done, transfers_aborted, items_ignored);
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/i2cmw_pkg.sv
src/i2cmw_front.sv
src/i2cmw_queue.sv
src/i2cmw_back.sv
src/i2c_master_write_sequencer.sv
tb/sv/testbench.sv
